[rtl/pla3d_pkg.sv]
// shared types for the 3d path length accumulator
package pla3d_pkg;

	// status reported by a multi-cycle arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

[rtl/pla3d_if.sv]
// valid/ready channel interfaces for waypoint and result words

interface pla3d_in_if #(
	parameter int COORD_BITS = 24
);
	logic                         valid;
	logic                         ready;
	logic                         new_route;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic signed [COORD_BITS-1:0] pos_z;

	modport source (output valid, new_route, pos_x, pos_y, pos_z, input ready);
	modport sink   (input valid, new_route, pos_x, pos_y, pos_z, output ready);
endinterface

interface pla3d_out_if #(
	parameter int SEG_BITS   = 25,
	parameter int TOTAL_BITS = 40
);
	logic                  valid;
	logic                  ready;
	logic [SEG_BITS-1:0]   segment_length;
	logic [TOTAL_BITS-1:0] total_length;
	logic                  no_distance;
	logic                  saturated;

	modport source (output valid, segment_length, total_length, no_distance, saturated,
		input ready);
	modport sink   (input valid, segment_length, total_length, no_distance, saturated,
		output ready);
endinterface

[rtl/pla3d_sqsum.sv]
// sum of squared coordinate differences through one shared multiplier
module pla3d_sqsum #(
	parameter int COORD_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [COORD_BITS-1:0]     cur_x,
	input  logic signed [COORD_BITS-1:0]     cur_y,
	input  logic signed [COORD_BITS-1:0]     cur_z,
	input  logic signed [COORD_BITS-1:0]     prev_x,
	input  logic signed [COORD_BITS-1:0]     prev_y,
	input  logic signed [COORD_BITS-1:0]     prev_z,
	output logic [2*COORD_BITS+1:0]          sum,
	output pla3d_pkg::unit_sts_t             sts
);

	localparam int DW = COORD_BITS + 1;
	localparam int SW = 2 * COORD_BITS + 2;

	// phase 0..2 load magnitudes, 1..3 square, 2..4 accumulate
	localparam logic [2:0] PH_LAST = 3'd4;

	logic                   busy_q;
	logic                   done_q;
	logic [2:0]             ph_q;
	logic [DW-1:0]          mag_q;
	logic [2*DW-1:0]        sq_q;
	logic [SW-1:0]          acc_q;

	logic signed [COORD_BITS-1:0] sel_a;
	logic signed [COORD_BITS-1:0] sel_b;
	logic signed [DW-1:0]         diff;
	logic [DW-1:0]                mag;

	// axis select and absolute difference
	always_comb begin
		case (ph_q)
			3'd0:    begin sel_a = cur_x; sel_b = prev_x; end
			3'd1:    begin sel_a = cur_y; sel_b = prev_y; end
			default: begin sel_a = cur_z; sel_b = prev_z; end
		endcase
		diff = $signed({sel_a[COORD_BITS-1], sel_a}) - $signed({sel_b[COORD_BITS-1], sel_b});
		mag  = diff[DW-1] ? DW'(~diff + 1'b1) : DW'(diff);
	end

	// phase counter and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= '0;
		end else begin
			done_q <= busy_q && (ph_q == PH_LAST);
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				ph_q   <= '0;
			end else if (busy_q) begin
				if (ph_q == PH_LAST) begin
					busy_q <= 1'b0;
				end else begin
					ph_q <= ph_q + 3'd1;
				end
			end
		end
	end

	// magnitude, square and accumulate registers
	always_ff @(posedge clk) begin
		mag_q <= mag;
		sq_q  <= mag_q * mag_q;
		if (busy_q) begin
			if (ph_q == 3'd2) begin
				acc_q <= SW'(sq_q);
			end else if (ph_q > 3'd2) begin
				acc_q <= acc_q + SW'(sq_q);
			end
		end
	end

	assign sum      = acc_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

[rtl/pla3d_isqrt.sv]
// floor integer square root, one result bit per cycle
module pla3d_isqrt #(
	parameter int COORD_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [2*COORD_BITS+1:0]  radicand,
	output logic [COORD_BITS:0]      root,
	output pla3d_pkg::unit_sts_t     sts
);

	localparam int NW    = 2 * COORD_BITS + 2;
	localparam int QW    = COORD_BITS + 1;
	localparam int RW    = COORD_BITS + 4;
	localparam int STEPS = COORD_BITS + 1;
	localparam int CW    = $clog2(STEPS + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] n_q;
	logic [RW-1:0] r_q;
	logic [QW-1:0] q_q;

	logic [RW-1:0] r_next;
	logic [RW-1:0] trial;
	logic          fits;

	// bring down two radicand bits and try the next root bit
	always_comb begin
		r_next = {r_q[RW-3:0], n_q[NW-1 -: 2]};
		trial  = RW'({q_q, 2'b01});
		fits   = (r_next >= trial);
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// remainder and partial root
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			n_q <= radicand;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[NW-3:0], 2'b00};
			if (fits) begin
				r_q <= r_next - trial;
				q_q <= {q_q[QW-2:0], 1'b1};
			end else begin
				r_q <= r_next;
				q_q <= {q_q[QW-2:0], 1'b0};
			end
		end
	end

	assign root     = q_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

[rtl/path_length_accumulator_3d.sv]
// 3d polyline length accumulator: top level and sequencer
//
// Waypoints come in on the wp channel (valid/ready), one word per point:
// new_route plus signed x, y, z in 1/16 metre. Each waypoint yields one
// result word on the res channel: floor segment length from the previous
// point, saturating route total, a zero-total flag and a saturation flag.
// The first point of a route (after reset or with new_route set) gives a
// zero segment and does no arithmetic: the sequencer goes from IDLE to FIN,
// loads the output register and returns to IDLE for the next waypoint.
// Any later point runs the three squared differences through one shared
// multiplier, then a one-bit-per-cycle square root of COORD_BITS + 1
// iterations, then the saturating add (ACC) and the output load (FIN).
// wp.ready is high only while the sequencer is idle, so one waypoint is in
// flight at a time and a new one is not taken before the last is through.
// The result sits in an output register; a new waypoint is accepted while
// it waits, and the next result waits in the sequencer until res.ready
// frees the register. Reset clears the previous point, the route total and
// all valid flags.
module path_length_accumulator_3d #(
	parameter int COORD_BITS = 24,
	parameter int TOTAL_BITS = 40
) (
	input  logic           clk,
	input  logic           arst_n,
	pla3d_in_if.sink       wp,
	pla3d_out_if.source    res
);

	localparam int SEGW = COORD_BITS + 1;
	localparam int SW   = 2 * COORD_BITS + 2;
	localparam int AW   = ((TOTAL_BITS > SEGW) ? TOTAL_BITS : SEGW) + 1;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

	typedef enum logic [2:0] {
		IDLE,
		SQ,
		RT,
		ACC,
		FIN
	} state_t;

	state_t                       state_q;
	logic                         have_prev_q;
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, cur_z_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic [SEGW-1:0]              seg_q;
	logic [TOTAL_BITS-1:0]        total_q;
	logic                         sq_start_q;
	logic                         rt_start_q;

	logic                         out_valid_q;
	logic [SEGW-1:0]              out_seg_q;
	logic [TOTAL_BITS-1:0]        out_total_q;
	logic                         out_zero_q;
	logic                         out_sat_q;

	logic [SW-1:0]                sq_sum;
	logic [SEGW-1:0]              root;
	pla3d_pkg::unit_sts_t         sq_sts;
	pla3d_pkg::unit_sts_t         rt_sts;

	logic                         in_ready;
	logic                         in_fire;
	logic                         out_load;
	logic [AW-1:0]                add_sum;
	logic [TOTAL_BITS-1:0]        total_next;

	// squared distance unit
	pla3d_sqsum #(
		.COORD_BITS(COORD_BITS)
	) u_sqsum (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start_q),
		.cur_x  (cur_x_q),
		.cur_y  (cur_y_q),
		.cur_z  (cur_z_q),
		.prev_x (prev_x_q),
		.prev_y (prev_y_q),
		.prev_z (prev_z_q),
		.sum    (sq_sum),
		.sts    (sq_sts)
	);

	// square root unit
	pla3d_isqrt #(
		.COORD_BITS(COORD_BITS)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rt_start_q),
		.radicand (sq_sum),
		.root     (root),
		.sts      (rt_sts)
	);

	// input handshake, output load and saturating add
	always_comb begin
		in_ready   = (state_q == IDLE) && !sq_sts.busy && !rt_sts.busy;
		in_fire    = wp.valid && in_ready;
		out_load   = (state_q == FIN) && (!out_valid_q || res.ready);
		add_sum    = AW'(total_q) + AW'(seg_q);
		total_next = (add_sum > AW'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_BITS'(add_sum);
	end

	assign wp.ready = in_ready;

	// sequencer, route state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			have_prev_q <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			cur_z_q     <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_z_q    <= '0;
			seg_q       <= '0;
			total_q     <= '0;
			sq_start_q  <= 1'b0;
			rt_start_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_seg_q   <= '0;
			out_total_q <= '0;
			out_zero_q  <= 1'b0;
			out_sat_q   <= 1'b0;
		end else begin
			sq_start_q <= in_fire && have_prev_q && !wp.new_route;
			rt_start_q <= (state_q == SQ) && sq_sts.done;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_fire) begin
						cur_x_q <= wp.pos_x;
						cur_y_q <= wp.pos_y;
						cur_z_q <= wp.pos_z;
						if (wp.new_route) begin
							total_q     <= '0;
							have_prev_q <= 1'b0;
						end
						if (have_prev_q && !wp.new_route) begin
							state_q <= SQ;
						end else begin
							seg_q   <= '0;
							state_q <= FIN;
						end
					end
				end
				SQ: begin
					if (sq_sts.done) begin
						state_q <= RT;
					end
				end
				RT: begin
					if (rt_sts.done) begin
						seg_q   <= root;
						state_q <= ACC;
					end
				end
				ACC: begin
					total_q <= total_next;
					state_q <= FIN;
				end
				FIN: begin
					if (out_load) begin
						out_seg_q   <= seg_q;
						out_total_q <= total_q;
						out_zero_q  <= (total_q == '0);
						out_sat_q   <= (total_q == TOTAL_MAX);
						prev_x_q    <= cur_x_q;
						prev_y_q    <= cur_y_q;
						prev_z_q    <= cur_z_q;
						have_prev_q <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// result channel
	assign res.valid          = out_valid_q;
	assign res.segment_length = out_seg_q;
	assign res.total_length   = out_total_q;
	assign res.no_distance    = out_zero_q;
	assign res.saturated      = out_sat_q;

endmodule
